[sv/wdao_pkg.sv]
`default_nettype none

package wdao_pkg;

    localparam int COUNT_BITS   = 20;
    localparam int RAW_BITS     = 16;
    localparam int SAMPLE_BITS  = 12;
    localparam int SUM_BITS     = 32;
    localparam int LEN_BITS     = 20;
    localparam int MODE_BITS    = 2;
    localparam int CHAR_BITS    = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int DIGIT_BITS   = 4;
    localparam int BCD_DIGITS   = 4;
    localparam int BCD_BITS     = BCD_DIGITS * DIGIT_BITS;
    localparam int STEP_BITS    = $clog2(SUM_BITS);
    localparam int STATE_BITS   = 3;

    typedef logic [RAW_BITS-1:0]     raw_t;
    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [SUM_BITS-1:0]     sum_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [LEN_BITS-1:0]     len_t;
    typedef logic [MODE_BITS-1:0]    mode_t;
    typedef logic [CHAR_BITS-1:0]    char_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    typedef logic [BCD_BITS-1:0]     bcd_t;
    typedef logic [DIGIT_BITS-1:0]   digit_t;
    typedef logic [STEP_BITS-1:0]    step_t;
    typedef logic [STATE_BITS-1:0]   state_t;

    localparam len_t LEN_RESET = 20'd9836;

    localparam cfg_idx_t REG_WINDOW_LENGTH = 2'd0;
    localparam cfg_idx_t REG_REDUCE_MODE   = 2'd1;

    localparam mode_t MODE_PEAK = 2'd0;
    localparam mode_t MODE_MEAN = 2'd1;

    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_CR   = 8'h0D;
    localparam char_t CHAR_LF   = 8'h0A;

    localparam state_t S_IDLE  = 3'd0;
    localparam state_t S_DIV   = 3'd1;
    localparam state_t S_CONV  = 3'd2;
    localparam state_t S_DIGIT = 3'd3;
    localparam state_t S_CR    = 3'd4;
    localparam state_t S_LF    = 3'd5;

endpackage

`default_nettype wire

[sv/wdao_if.sv]
`default_nettype none

interface wdao_sample_if;
    import wdao_pkg::*;
    logic valid;
    logic ready;
    raw_t raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

interface wdao_char_if;
    import wdao_pkg::*;
    logic  valid;
    logic  ready;
    char_t out_char;
    logic  end_of_record;
    modport source (output valid, output out_char, output end_of_record, input ready);
    modport sink (input valid, input out_char, input end_of_record, output ready);
endinterface

interface wdao_cfg_if;
    import wdao_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    len_t     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/window_decimator_ascii_out.sv]
`default_nettype none

// channel   dir   payload                          request
// cfg       in    index (2b), data (20b)           one register write
// samples   in    raw_sample (16b, low 12 used)    one converter word
// chars     out   out_char (8b), end_of_record     one ascii byte
//
// samples that do not close the window are taken back to back while the block is idle
// a closing sample goes through bit-serial division in mean mode, then bcd conversion,
// then up to 4 digits plus cr and lf are sent
// samples are held off from the closing sample until lf is in the output register
// rst_n clears the window, the registers to their defaults and the output valid flag
// a stalled output holds the current byte and freezes the digit sequencer, though leading zeros are still skipped

module window_decimator_ascii_out (
    input  wire         clk,
    input  wire         rst_n,
    wdao_cfg_if.sink    cfg,
    wdao_sample_if.sink samples,
    wdao_char_if.source chars
);
    import wdao_pkg::*;

    state_t  state_reg, state_next;
    len_t    len_reg;
    mode_t   mode_reg;
    count_t  cnt_reg, cnt_next;
    sum_t    sum_reg, sum_next;
    sample_t peak_reg, peak_next;

    sum_t    quo_reg, quo_next;
    count_t  rem_reg, rem_next;
    count_t  den_reg, den_next;
    step_t   step_reg, step_next;
    sample_t bin_reg, bin_next;
    bcd_t    bcd_reg, bcd_next;
    logic    started_reg, started_next;

    logic    ovalid_reg, ovalid_next;
    char_t   ochar_reg, ochar_next;
    logic    oeor_reg, oeor_next;

    sample_t             v;
    sum_t                sum_add;
    sample_t             peak_upd;
    count_t              cnt_inc;
    len_t                len_eff;
    logic                close_win;
    logic [COUNT_BITS:0] rem_shift;
    logic [COUNT_BITS:0] diff;
    logic                div_fit;
    sum_t                quo_step;
    bcd_t                bcd_adj;
    digit_t              lead;
    logic                show;
    logic                out_free;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == S_IDLE);

    assign chars.valid         = ovalid_reg;
    assign chars.out_char      = ochar_reg;
    assign chars.end_of_record = oeor_reg;

    assign v         = samples.raw_sample[SAMPLE_BITS-1:0];
    assign sum_add   = sum_reg + SUM_BITS'(v);
    assign peak_upd  = (v > peak_reg) ? v : peak_reg;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign len_eff   = (len_reg == '0) ? LEN_BITS'(1) : len_reg;
    assign close_win = (SUM_BITS'(cnt_inc) >= SUM_BITS'(len_eff)) || (cnt_inc == '1);

    assign rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign div_fit   = !diff[COUNT_BITS];
    assign quo_step  = {quo_reg[SUM_BITS-2:0], div_fit};

    assign lead     = bcd_reg[BCD_BITS-1 -: DIGIT_BITS];
    assign show     = (lead != '0) || started_reg || (step_reg == '0);
    assign out_free = !ovalid_reg || chars.ready;

    always_comb
    begin
        digit_t nib;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            nib = bcd_reg[i*DIGIT_BITS +: DIGIT_BITS];
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            mode_reg <= MODE_PEAK;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_LENGTH: len_reg <= cfg.data;
                REG_REDUCE_MODE:   mode_reg <= cfg.data[MODE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        peak_next    = peak_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        step_next    = step_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg;
        ochar_next   = ochar_reg;
        oeor_next    = oeor_reg;

        if (chars.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    if (close_win)
                    begin
                        cnt_next  = '0;
                        sum_next  = '0;
                        peak_next = '0;
                        step_next = '0;
                        bcd_next  = '0;
                        if (mode_reg == MODE_MEAN)
                        begin
                            if (cnt_inc == '0)
                            begin
                                bin_next   = '0;
                                state_next = S_CONV;
                            end
                            else
                            begin
                                quo_next   = sum_add;
                                rem_next   = '0;
                                den_next   = cnt_inc;
                                state_next = S_DIV;
                            end
                        end
                        else
                        begin
                            bin_next   = (mode_reg == MODE_PEAK) ? peak_upd : v;
                            state_next = S_CONV;
                        end
                    end
                    else
                    begin
                        cnt_next  = cnt_inc;
                        sum_next  = sum_add;
                        peak_next = peak_upd;
                    end
                end
            end

            S_DIV:
            begin
                quo_next  = quo_step;
                rem_next  = div_fit ? diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                begin
                    bin_next   = quo_step[SAMPLE_BITS-1:0];
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = S_CONV;
                end
            end

            S_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_BITS-2:0], bin_reg[SAMPLE_BITS-1]};
                bin_next  = {bin_reg[SAMPLE_BITS-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(SAMPLE_BITS - 1))
                begin
                    step_next    = STEP_BITS'(BCD_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = S_DIGIT;
                end
            end

            S_DIGIT:
            begin
                if (!show)
                begin
                    bcd_next  = {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    step_next = step_reg - 1'b1;
                end
                else if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ochar_next   = CHAR_ZERO + CHAR_BITS'(lead);
                    oeor_next    = 1'b0;
                    bcd_next     = {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    started_next = 1'b1;
                    if (step_reg == '0)
                    begin
                        state_next = S_CR;
                    end
                    else
                    begin
                        step_next = step_reg - 1'b1;
                    end
                end
            end

            S_CR:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_CR;
                    oeor_next   = 1'b0;
                    state_next  = S_LF;
                end
            end

            S_LF:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_LF;
                    oeor_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            peak_reg    <= '0;
            step_reg    <= '0;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            peak_reg    <= peak_next;
            step_reg    <= step_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        ochar_reg <= ochar_next;
        oeor_reg  <= oeor_next;
    end

endmodule

`default_nettype wire
